// ===== hdl/wvsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Wheel vector slew limiter package
// Shared widths, constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package wvsl_pkg;

   localparam int WHEEL_COUNT_DEFAULT = 4;
   localparam int SPEED_BITS_DEFAULT  = 20;

   localparam int TICK_BITS     = 16;
   localparam int SLEW_BITS     = 24;
   localparam int LIMIT_BITS    = 19;
   localparam int ALLOWED_BITS  = 24;
   localparam int CSR_DATA_BITS = 24;

   // serial unit widths for the default speed width
   localparam int MUL_B_BITS_DEFAULT   = SPEED_BITS_DEFAULT + 1;
   localparam int DIVIDEND_BITS_DEFAULT = ALLOWED_BITS + MUL_B_BITS_DEFAULT;
   localparam int DIVISOR_BITS_DEFAULT  = MUL_B_BITS_DEFAULT;

   localparam logic [TICK_BITS-1:0]  TICK_MIN_US  = 16'd100;
   localparam logic [TICK_BITS-1:0]  TICK_MAX_US  = 16'd50000;
   // slew/256 * tick/1e6 * 4096 = slew * tick / 62500
   localparam logic [TICK_BITS-1:0]  STEP_DIVISOR = 16'd62500;

   localparam logic [SLEW_BITS-1:0]  SLEW_RESET  = 24'd0;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 19'h7FFFF;

   typedef enum logic [0:0] {
      CSR_SLEW_LIMIT  = 1'b0,
      CSR_SPEED_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      MODE_SHARED = 1'b0,
      MODE_DIRECT = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP_MUL,
      ST_STEP_DIV,
      ST_PEAK,
      ST_WHEEL,
      ST_SCALE_MUL,
      ST_SCALE_DIV,
      ST_APPLY,
      ST_OUTPUT
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/wvsl_serial_mul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add unsigned multiply, one multiplier bit per cycle, narrow adder.
// ----------------------------------------------------------------------------
`default_nettype none

module wvsl_serial_mul #(
   parameter int A_BITS = wvsl_pkg::ALLOWED_BITS,
   parameter int B_BITS = wvsl_pkg::MUL_B_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [A_BITS-1:0]          a,
   input  wire logic [B_BITS-1:0]          b,
   output logic                            done,
   output logic      [A_BITS+B_BITS-1:0]   product
);

   import wvsl_pkg::*;

   localparam int CNT_BITS = $clog2(B_BITS + 1);

   logic [A_BITS-1:0]   a_ff, a_in;
   logic [A_BITS-1:0]   hi_ff, hi_in;
   logic [B_BITS-1:0]   lo_ff, lo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic [A_BITS:0]     sum;

   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(A_BITS+1){1'b0}});
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = a;
         hi_in  = '0;
         lo_in  = b;
         cnt_in = CNT_BITS'(B_BITS);
      end else if (cnt_ff != '0) begin
         // add on the low bit, then shift the whole product right
         hi_in   = sum[A_BITS:1];
         lo_in   = {sum[0], lo_ff[B_BITS-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

// ===== hdl/wvsl_serial_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring unsigned divide, one quotient bit per cycle. Divisor is nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module wvsl_serial_div #(
   parameter int DIVIDEND_BITS = wvsl_pkg::DIVIDEND_BITS_DEFAULT,
   parameter int DIVISOR_BITS  = wvsl_pkg::DIVISOR_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [DIVIDEND_BITS-1:0]  dividend,
   input  wire logic [DIVISOR_BITS-1:0]   divisor,
   output logic                           done,
   output logic      [DIVIDEND_BITS-1:0]  quotient
);

   import wvsl_pkg::*;

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS+1:0]  diff;
   logic                     borrow;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      borrow  = diff[DIVISOR_BITS+1];
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dsr_in = divisor;
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_BITS'(DIVIDEND_BITS);
      end else if (cnt_ff != '0) begin
         // keep the trial difference only when it did not borrow
         rem_in  = borrow ? shifted[DIVISOR_BITS-1:0] : diff[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], ~borrow};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/wheel_vector_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// Wheel vector slew limiter
// Limits the change of a wheel speed vector per control tick, either by a
// shared scale on the whole vector or per wheel, then saturates each speed.
// ----------------------------------------------------------------------------
// MB = max(16, SPEED_BITS+1), PW = 24 + MB. Each wheel that is scaled in
// shared mode also runs the bit-serial multiplier (MB bits) and the
// one-bit-per-cycle divider (PW bits). One word in flight at a time.
// Reset: last speeds clear to zero, slew limit to zero, speed limit to max.
`default_nettype none

module wheel_vector_slew_limiter #(
   parameter int WHEEL_COUNT = wvsl_pkg::WHEEL_COUNT_DEFAULT,
   parameter int SPEED_BITS  = wvsl_pkg::SPEED_BITS_DEFAULT,
   localparam int REQ_RAW_BITS  = wvsl_pkg::TICK_BITS + WHEEL_COUNT * SPEED_BITS,
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((WHEEL_COUNT * SPEED_BITS + 7) / 8) * 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // tick_us, target_a, target_b, ... (SPEED_BITS each), zero pad
   input  wire logic [REQ_DATA_BITS-1:0]              req_tdata,
   // command
   input  wire logic                                  req_tuser,
   // response
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // speed_a, speed_b, ... (SPEED_BITS each), zero pad
   output logic      [RSP_DATA_BITS-1:0]              rsp_tdata,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire wvsl_pkg::csr_index_type               csr_index,
   input  wire logic [wvsl_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   import wvsl_pkg::*;

   localparam int IW   = $clog2(WHEEL_COUNT);
   localparam int DW   = SPEED_BITS + 1;
   localparam int MB   = (TICK_BITS > DW) ? TICK_BITS : DW;
   localparam int PW   = ALLOWED_BITS + MB;
   localparam int CMPW = (DW > ALLOWED_BITS) ? DW : ALLOWED_BITS;
   localparam int CW   = ((SPEED_BITS > LIMIT_BITS) ? SPEED_BITS : LIMIT_BITS) + 2;
   localparam logic [IW-1:0] LAST_IDX = IW'(WHEEL_COUNT - 1);

   state_type state_ff, state_in;

   logic [SLEW_BITS-1:0]           slew_ff, slew_in;
   logic [LIMIT_BITS-1:0]          limit_ff, limit_in;
   mode_type                       mode_ff, mode_in;
   logic [IW-1:0]                  idx_ff, idx_in;
   logic [ALLOWED_BITS-1:0]        allowed_ff, allowed_in;
   logic [DW-1:0]                  peak_ff, peak_in;
   logic [DW-1:0]                  mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic signed [SPEED_BITS-1:0]   target_ff [WHEEL_COUNT];
   logic signed [SPEED_BITS-1:0]   target_in [WHEEL_COUNT];
   logic signed [SPEED_BITS-1:0]   last_ff   [WHEEL_COUNT];
   logic signed [SPEED_BITS-1:0]   last_in   [WHEEL_COUNT];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]       rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic [TICK_BITS-1:0]    tick_raw, tick_clamped;
   logic [DW-1:0]           delta, dmag, clamp_mag;
   logic                    dneg, scale, last_wheel, rsp_load;
   logic signed [CW-1:0]    last_ext, step_ext, sum_ext, lim_ext, sat;

   logic                    mul_start, mul_done;
   logic [ALLOWED_BITS-1:0] mul_a;
   logic [MB-1:0]           mul_b;
   logic [PW-1:0]           mul_product;
   logic                    div_start, div_done;
   logic [PW-1:0]           div_dividend, div_quotient;
   logic [MB-1:0]           div_divisor;

   wvsl_serial_mul #(
      .A_BITS (ALLOWED_BITS),
      .B_BITS (MB)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   wvsl_serial_div #(
      .DIVIDEND_BITS (PW),
      .DIVISOR_BITS  (MB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // per-wheel arithmetic on the selected wheel
   always_comb begin
      accept   = req_tvalid && (state_ff == ST_IDLE);
      tick_raw = req_tdata[TICK_BITS-1:0];
      if (tick_raw < TICK_MIN_US) begin
         tick_clamped = TICK_MIN_US;
      end else if (tick_raw > TICK_MAX_US) begin
         tick_clamped = TICK_MAX_US;
      end else begin
         tick_clamped = tick_raw;
      end
      delta      = {target_ff[idx_ff][SPEED_BITS-1], target_ff[idx_ff]}
                 - {last_ff[idx_ff][SPEED_BITS-1], last_ff[idx_ff]};
      dneg       = delta[DW-1];
      dmag       = dneg ? (~delta + 1'b1) : delta;
      scale      = (mode_ff == MODE_SHARED) && (CMPW'(peak_ff) > CMPW'(allowed_ff));
      clamp_mag  = (CMPW'(dmag) > CMPW'(allowed_ff)) ? DW'(allowed_ff) : dmag;
      last_wheel = (idx_ff == LAST_IDX);
      last_ext   = CW'(last_ff[idx_ff]);
      step_ext   = CW'(signed'({1'b0, mag_ff}));
      sum_ext    = neg_ff ? (last_ext - step_ext) : (last_ext + step_ext);
      lim_ext    = CW'(signed'({1'b0, limit_ff}));
      if (sum_ext > lim_ext) begin
         sat = lim_ext;
      end else if (sum_ext < -lim_ext) begin
         sat = -lim_ext;
      end else begin
         sat = sum_ext;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_STEP_MUL;
         ST_STEP_MUL:  if (mul_done) state_in = ST_STEP_DIV;
         ST_STEP_DIV:  if (div_done) state_in = ST_PEAK;
         ST_PEAK:      if (last_wheel) state_in = ST_WHEEL;
         ST_WHEEL:     state_in = scale ? ST_SCALE_MUL : ST_APPLY;
         ST_SCALE_MUL: if (mul_done) state_in = ST_SCALE_DIV;
         ST_SCALE_DIV: if (div_done) state_in = ST_APPLY;
         ST_APPLY:     state_in = last_wheel ? ST_OUTPUT : ST_WHEEL;
         ST_OUTPUT:    if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // unit controls and handshake
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      mul_start    = 1'b0;
      mul_a        = slew_ff;
      mul_b        = MB'(tick_clamped);
      div_start    = 1'b0;
      div_dividend = mul_product;
      div_divisor  = MB'(STEP_DIVISOR);
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE:      mul_start = accept;
         ST_STEP_MUL:  div_start = mul_done;
         ST_WHEEL: begin
            mul_start = scale;
            mul_a     = allowed_ff;
            mul_b     = MB'(dmag);
         end
         ST_SCALE_MUL: begin
            div_start   = mul_done;
            div_divisor = MB'(peak_ff);
         end
         ST_OUTPUT:    rsp_load = !rsp_valid_ff || rsp_tready;
         ST_STEP_DIV, ST_PEAK, ST_SCALE_DIV, ST_APPLY: ;
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      slew_in      = slew_ff;
      limit_in     = limit_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      allowed_in   = allowed_ff;
      peak_in      = peak_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      target_in    = target_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SLEW_LIMIT:  slew_in  = csr_data[SLEW_BITS-1:0];
            CSR_SPEED_LIMIT: limit_in = csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         mode_in = mode_type'(req_tuser);
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            target_in[i] = req_tdata[TICK_BITS + i*SPEED_BITS +: SPEED_BITS];
         end
      end

      unique case (state_ff)
         ST_STEP_DIV: begin
            if (div_done) begin
               allowed_in = div_quotient[ALLOWED_BITS-1:0];
               peak_in    = '0;
               idx_in     = '0;
            end
         end
         ST_PEAK: begin
            if (dmag > peak_ff) peak_in = dmag;
            idx_in = last_wheel ? '0 : idx_ff + 1'b1;
         end
         ST_WHEEL: begin
            neg_in = dneg;
            mag_in = clamp_mag;
         end
         ST_SCALE_DIV: begin
            if (div_done) mag_in = div_quotient[DW-1:0];
         end
         ST_APPLY: begin
            last_in[idx_ff] = sat[SPEED_BITS-1:0];
            idx_in          = last_wheel ? '0 : idx_ff + 1'b1;
         end
         ST_OUTPUT: begin
            if (rsp_load) begin
               rsp_data_in = '0;
               for (int i = 0; i < WHEEL_COUNT; i++) begin
                  rsp_data_in[i*SPEED_BITS +: SPEED_BITS] = last_ff[i];
               end
               rsp_valid_in = 1'b1;
            end
         end
         ST_IDLE, ST_STEP_MUL, ST_SCALE_MUL: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slew_ff      <= SLEW_RESET;
         limit_ff     <= LIMIT_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slew_ff      <= slew_in;
         limit_ff     <= limit_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      allowed_ff  <= allowed_in;
      peak_ff     <= peak_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      target_ff   <= target_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
